[sv/mplc_pkg.sv]
// Shared types and constants for the matching-pair loop counter.
// Holds field widths, the sequencer state type and the lane control bundle.
// No dependencies.
`default_nettype none

package mplc_pkg;

	localparam int PEER_W  = 4;
	localparam int PAIR_W  = 64;
	localparam int CFG_W   = 5;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SPREAD,
		ST_FINISH
	} seq_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} lane_ctl_t;

endpackage

`default_nettype wire

[sv/mplc_lane.sv]
// One point lane: builds the adjacency row of its point and then widens it
// into a reachability row by repeated squaring. Depends on mplc_pkg.
`default_nettype none

module mplc_lane #(
	parameter int MAX_POINTS = 16,
	parameter int LANE       = 0
) (
	input  wire                                   clk,
	input  wire mplc_pkg::lane_ctl_t              ctl,
	input  wire [mplc_pkg::PEER_W-1:0]            peer_a [MAX_POINTS],
	input  wire [mplc_pkg::PEER_W-1:0]            peer_b [MAX_POINTS],
	input  wire [mplc_pkg::CFG_W-1:0]             points,
	input  wire [MAX_POINTS-1:0]                  reach_all [MAX_POINTS],
	output logic [MAX_POINTS-1:0]                 reach_q
);
	import mplc_pkg::*;

	logic [MAX_POINTS-1:0] adj_row;
	logic [MAX_POINTS-1:0] grown;
	logic                  own_in_use;

	assign own_in_use = CFG_W'(LANE) < points;

	// Edges leaving this point, plus edges from other points in use that
	// name this point, so that the graph is treated as undirected.
	always_comb begin
		adj_row = '0;
		for (int j = 0; j < MAX_POINTS; j++) begin
			adj_row[j] = (j == LANE)
				|| (own_in_use && (peer_a[LANE] == PEER_W'(j)))
				|| (own_in_use && (peer_b[LANE] == PEER_W'(j)))
				|| ((CFG_W'(j) < points)
					&& ((peer_a[j] == PEER_W'(LANE)) || (peer_b[j] == PEER_W'(LANE))));
		end
	end

	always_comb begin
		grown = reach_q;
		for (int k = 0; k < MAX_POINTS; k++) begin
			if (reach_q[k]) begin
				grown = grown | reach_all[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			reach_q <= adj_row;
		end else if (ctl.step) begin
			reach_q <= grown;
		end
	end

endmodule

`default_nettype wire

[sv/mplc_merge.sv]
// Merging stage: a point in use whose reachability row holds no lower point
// is the root of its component, and the roots are counted (zero when bad is set).
// Depends on mplc_pkg.
`default_nettype none

module mplc_merge #(
	parameter int MAX_POINTS = 16
) (
	input  wire [MAX_POINTS-1:0]          reach_all [MAX_POINTS],
	input  wire [mplc_pkg::CFG_W-1:0]     points,
	input  wire                           bad,
	output logic [mplc_pkg::COUNT_W-1:0]  loops
);
	import mplc_pkg::*;

	logic [MAX_POINTS-1:0] root;
	logic [COUNT_W-1:0]    total;

	always_comb begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			root[i] = CFG_W'(i) < points;
			for (int j = 0; j < i; j++) begin
				if (reach_all[i][j]) begin
					root[i] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		total = '0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			total = total + COUNT_W'(root[i]);
		end
	end

	assign loops = bad ? '0 : total;

endmodule

`default_nettype wire

[sv/matching_pair_loop_count.sv]
// Top level of the matching-pair loop counter: configuration register,
// sequencer, point lanes and merging stage. Depends on mplc_pkg, mplc_lane
// and mplc_merge.
//
//   channel  direction  handshake                 payload
//   cfg      in         cfg_we                    cfg_wdata (strands_in_use)
//   in       in         in_valid / in_ready       first_pairing, second_pairing
//   out      out        out_valid / out_ready     loop_count, bad_peer
//
// Per item: the beat is latched on leaving idle, the load state builds the
// adjacency rows, the spread state makes clog2(MAX_POINTS) squaring steps of
// the lane rows, and the finish state counts roots into the output register.
// The output register frees the input side: a new beat is taken while a
// result waits, and only the final count stalls while out_ready is low.
// Reset clears the sequencer and output valid and sets strands_in_use to 16.
`default_nettype none

module matching_pair_loop_count #(
	parameter int MAX_POINTS = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [mplc_pkg::CFG_W-1:0]         cfg_wdata,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire [mplc_pkg::PAIR_W-1:0]        first_pairing,
	input  wire [mplc_pkg::PAIR_W-1:0]        second_pairing,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [mplc_pkg::COUNT_W-1:0]      loop_count,
	output logic                              bad_peer
);
	import mplc_pkg::*;

	localparam int ITER  = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(ITER + 1);

	logic [CFG_W-1:0]      strands_q;
	logic [CFG_W-1:0]      points_q;
	logic [PEER_W-1:0]     peer_a_q [MAX_POINTS];
	logic [PEER_W-1:0]     peer_b_q [MAX_POINTS];
	logic [MAX_POINTS-1:0] reach [MAX_POINTS];
	logic                  bad_q;
	logic                  bad_now;
	logic [CNT_W-1:0]      step_cnt_q;
	logic [COUNT_W-1:0]    loops;
	logic [COUNT_W-1:0]    loop_count_q;
	logic                  bad_peer_q;
	logic                  out_valid_q;

	seq_state_t state_q;
	seq_state_t state_nxt;
	lane_ctl_t  ctl;
	logic       capture;
	logic       out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strands_q <= CFG_W'(16);
		end else if (cfg_we) begin
			strands_q <= cfg_wdata;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE:   state_nxt = in_valid ? ST_LOAD : ST_IDLE;
			ST_LOAD:   state_nxt = ST_SPREAD;
			ST_SPREAD: state_nxt = (step_cnt_q == CNT_W'(ITER - 1)) ? ST_FINISH : ST_SPREAD;
			ST_FINISH: state_nxt = (!out_valid_q || out_ready) ? ST_IDLE : ST_FINISH;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		ctl.load = (state_q == ST_LOAD);
		ctl.step = (state_q == ST_SPREAD);
		out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	assign capture = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (ctl.load) begin
				step_cnt_q <= '0;
			end else if (ctl.step) begin
				step_cnt_q <= step_cnt_q + CNT_W'(1);
			end
		end
	end

	// Beat capture; the point count saturates at the number of lanes.
	always_ff @(posedge clk) begin
		if (capture) begin
			points_q <= (strands_q > CFG_W'(MAX_POINTS)) ? CFG_W'(MAX_POINTS) : strands_q;
			for (int i = 0; i < MAX_POINTS; i++) begin
				peer_a_q[i] <= first_pairing[i*PEER_W +: PEER_W];
				peer_b_q[i] <= second_pairing[i*PEER_W +: PEER_W];
			end
		end
	end

	always_comb begin
		bad_now = 1'b0;
		for (int i = 0; i < MAX_POINTS; i++) begin
			if ((CFG_W'(i) < points_q)
				&& ((CFG_W'(peer_a_q[i]) >= points_q) || (CFG_W'(peer_b_q[i]) >= points_q))) begin
				bad_now = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			bad_q <= bad_now;
		end
	end

	for (genvar g = 0; g < MAX_POINTS; g++) begin : g_lane
		mplc_lane #(
			.MAX_POINTS(MAX_POINTS),
			.LANE      (g)
		) u_lane (
			.clk      (clk),
			.ctl      (ctl),
			.peer_a   (peer_a_q),
			.peer_b   (peer_b_q),
			.points   (points_q),
			.reach_all(reach),
			.reach_q  (reach[g])
		);
	end

	mplc_merge #(
		.MAX_POINTS(MAX_POINTS)
	) u_merge (
		.reach_all(reach),
		.points   (points_q),
		.bad      (bad_q),
		.loops    (loops)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			loop_count_q <= loops;
			bad_peer_q   <= bad_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign loop_count = loop_count_q;
	assign bad_peer   = bad_peer_q;

endmodule

`default_nettype wire
